### hdl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg: shared definitions for the threshold promote page cache
// Field widths, register indexes, reset values, the sequencer state type
// and the control group that steers one cell of the entry row.
// ----------------------------------------------------------------------------
`default_nettype none

package tpc_pkg;

  // Default sizes handed to the top level.
  localparam int CAPACITY_DEFAULT = 16;
  localparam int KEY_BITS_DEFAULT = 32;

  // Fixed port widths.
  localparam int PAGE_KEY_BITS    = 32;
  localparam int COUNT_BITS       = 16;
  localparam int ENTRY_COUNT_BITS = 5;
  localparam int MAX_ENTRIES_BITS = 5;
  localparam int CFG_INDEX_BITS   = 2;
  localparam int CFG_DATA_BITS    = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_ENTRIES       = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PROMOTE_THRESHOLD = 2'd1;

  // Register reset values.
  localparam logic [MAX_ENTRIES_BITS-1:0] MAX_ENTRIES_RESET = 5'd16;
  localparam logic [COUNT_BITS-1:0]       THRESHOLD_RESET   = 16'd1;

  // Saturation point and start value of a request count.
  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [COUNT_BITS-1:0] COUNT_FIRST = 16'd1;

  // Request sequencer: compare cycle, then update cycle.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } tpc_state_t;

  // Per-cell control: capture compare flags, take the neighbor's entry,
  // or load a new count in place.
  typedef struct packed {
    logic capture;
    logic shift;
    logic load;
  } tpc_cell_ctrl_t;

endpackage

`default_nettype wire

### hdl/tpc_cell.sv
// ----------------------------------------------------------------------------
// tpc_cell: one entry of the ordered page list
// Holds a key and its count, compares the key with the request and passes
// a "no hit ahead" flag and its entry on to the next cell in the row.
// ----------------------------------------------------------------------------
`default_nettype none

module tpc_cell #(
  parameter int KW = 32
) (
  input  wire logic                          clk,
  input  wire tpc_pkg::tpc_cell_ctrl_t       ctrl,
  input  wire logic                          valid,
  input  wire logic [KW-1:0]                 req_key,
  input  wire logic                          clear_in,
  output logic                               clear_out,
  output logic                               first,
  input  wire logic [KW-1:0]                 key_in,
  input  wire logic [tpc_pkg::COUNT_BITS-1:0] count_in,
  input  wire logic [tpc_pkg::COUNT_BITS-1:0] new_count,
  output logic [KW-1:0]                      key_r,
  output logic [tpc_pkg::COUNT_BITS-1:0]     count_r,
  output logic                               first_r,
  output logic                               clear_r
);

  logic                           match;
  logic [KW-1:0]                  key_nxt;
  logic [tpc_pkg::COUNT_BITS-1:0] count_nxt;

  // Compare against the request; the first matching cell in the row wins.
  assign match     = valid && (key_r == req_key);
  assign first     = match && clear_in;
  assign clear_out = clear_in && !match;

  // Entry update: shift from the neighbor, or bump the count in place.
  always_comb begin
    key_nxt   = key_r;
    count_nxt = count_r;
    if (ctrl.shift) begin
      key_nxt   = key_in;
      count_nxt = count_in;
    end else if (ctrl.load) begin
      count_nxt = new_count;
    end
  end

  // Entry storage has no reset; the list length marks what is valid.
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    count_r <= count_nxt;
    if (ctrl.capture) begin
      first_r <= first;
      clear_r <= clear_in;
    end
  end

endmodule

`default_nettype wire

### hdl/threshold_promote_page_cache.sv
// Sequence: an accepted request passes the compare state and then the update state;
// its result strobe is registered from the update state. Requests: start is not taken
// during the compare cycle of the cell row; start is taken again during the shift cycle.
// Reset: list length cleared, max_entries to 16 and promote_threshold to 1;
// the entry cells are not cleared, so there is no sweep after reset.
// The result is a single-cycle strobe; the receiver cannot stall it.
// ----------------------------------------------------------------------------
// threshold_promote_page_cache: move-to-front page list with a count threshold
// A row of cells keeps the page list front first. Misses insert at the front
// and may evict the last entry; hits count up and move forward past a threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module threshold_promote_page_cache #(
  parameter int CAPACITY = tpc_pkg::CAPACITY_DEFAULT,
  parameter int KEY_BITS = tpc_pkg::KEY_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [tpc_pkg::PAGE_KEY_BITS-1:0]   in_page_key,
  output logic                                     out_valid,
  output logic                                     out_hit,
  output logic [tpc_pkg::COUNT_BITS-1:0]           out_request_count,
  output logic                                     out_promoted,
  output logic                                     out_evicted,
  output logic [tpc_pkg::PAGE_KEY_BITS-1:0]        out_evicted_key,
  output logic [tpc_pkg::ENTRY_COUNT_BITS-1:0]     out_entry_count,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tpc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [tpc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int KW = (KEY_BITS < tpc_pkg::PAGE_KEY_BITS) ? KEY_BITS : tpc_pkg::PAGE_KEY_BITS;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = tpc_pkg::COUNT_BITS;

  tpc_pkg::tpc_state_t state_r, state_nxt;

  logic                                  accept;
  logic [KW-1:0]                         req_key_r;
  logic [LW-1:0]                         len_r, len_nxt;
  logic [tpc_pkg::MAX_ENTRIES_BITS-1:0]  max_entries_r;
  logic [CW-1:0]                         threshold_r;

  // Compare results carried into the update cycle.
  logic          found_r;
  logic [CW-1:0] sel_count_r, sel_count_nxt;
  logic [KW-1:0] last_key_r, last_key_nxt;

  // Cell row wiring.
  logic [CAPACITY:0]         clear_chain;
  logic [CAPACITY-1:0]       cell_first;
  logic [CAPACITY-1:0]       cell_first_r;
  logic [CAPACITY-1:0]       cell_clear_r;
  logic [CAPACITY-1:0]       cell_valid;
  logic [CAPACITY-1:0]       cell_last;
  logic [KW-1:0]             cell_key   [CAPACITY];
  logic [CW-1:0]             cell_count [CAPACITY];
  tpc_pkg::tpc_cell_ctrl_t   cell_ctrl  [CAPACITY];

  // Update-cycle decisions.
  logic          upd;
  logic          miss;
  logic          promote;
  logic          evict;
  logic [CW-1:0] new_count;
  logic [CW-1:0] head_count;
  logic [31:0]   limit;

  // Result registers.
  logic                                 out_valid_r;
  logic                                 out_hit_r;
  logic [CW-1:0]                        out_count_r;
  logic                                 out_promoted_r;
  logic                                 out_evicted_r;
  logic [tpc_pkg::PAGE_KEY_BITS-1:0]    out_evicted_key_r;
  logic [tpc_pkg::ENTRY_COUNT_BITS-1:0] out_entry_count_r;

  // Sequencer: a new request may enter while the previous one updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    busy   = (state_r == tpc_pkg::ST_CMP);
    accept = start && !busy;
    unique case (state_r)
      tpc_pkg::ST_IDLE: state_nxt = accept ? tpc_pkg::ST_CMP : tpc_pkg::ST_IDLE;
      tpc_pkg::ST_CMP:  state_nxt = tpc_pkg::ST_UPD;
      tpc_pkg::ST_UPD:  state_nxt = accept ? tpc_pkg::ST_CMP : tpc_pkg::ST_IDLE;
      default:          state_nxt = tpc_pkg::ST_IDLE;
    endcase
  end

  // Request key, masked to the stored key width.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_key_r <= in_page_key[KW-1:0];
    end
  end

  // Configuration registers; the port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= tpc_pkg::MAX_ENTRIES_RESET;
      threshold_r   <= tpc_pkg::THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == tpc_pkg::CFG_MAX_ENTRIES) begin
        max_entries_r <= cfg_data[tpc_pkg::MAX_ENTRIES_BITS-1:0];
      end else if (cfg_index == tpc_pkg::CFG_PROMOTE_THRESHOLD) begin
        threshold_r <= cfg_data[CW-1:0];
      end
    end
  end

  // Effective entry limit: zero acts as one, anything above the row acts as the row.
  always_comb begin
    priority if (max_entries_r == '0) begin
      limit = 32'd1;
    end else if (32'(max_entries_r) > 32'(CAPACITY)) begin
      limit = 32'(CAPACITY);
    end else begin
      limit = 32'(max_entries_r);
    end
  end

  // Update-cycle decisions from the registered compare results.
  assign upd        = (state_r == tpc_pkg::ST_UPD);
  assign miss       = !found_r;
  assign new_count  = (sel_count_r == tpc_pkg::COUNT_MAX) ? sel_count_r : sel_count_r + 1'b1;
  assign promote    = found_r && (new_count > threshold_r) && !cell_first_r[0];
  assign evict      = miss && (32'(len_r) >= limit);
  assign head_count = miss ? tpc_pkg::COUNT_FIRST : new_count;

  // The row of cells; cell zero takes the request as its neighbor entry.
  assign clear_chain[0] = 1'b1;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KW-1:0] key_in;
    logic [CW-1:0] count_in;

    assign cell_valid[i] = (LW'(i) < len_r);
    assign cell_last[i]  = (len_r != '0) && (LW'(i) == len_r - 1'b1);

    if (i == 0) begin : g_head
      assign key_in   = req_key_r;
      assign count_in = head_count;
    end else begin : g_body
      assign key_in   = cell_key[i-1];
      assign count_in = cell_count[i-1];
    end

    // Shift on a miss, or up to the hit position on a promotion.
    always_comb begin
      cell_ctrl[i].capture = (state_r == tpc_pkg::ST_CMP);
      cell_ctrl[i].shift   = upd && (miss || (promote && cell_clear_r[i]));
      cell_ctrl[i].load    = upd && found_r && !promote && cell_first_r[i];
    end

    tpc_cell #(
      .KW(KW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .valid     (cell_valid[i]),
      .req_key   (req_key_r),
      .clear_in  (clear_chain[i]),
      .clear_out (clear_chain[i+1]),
      .first     (cell_first[i]),
      .key_in    (key_in),
      .count_in  (count_in),
      .new_count (new_count),
      .key_r     (cell_key[i]),
      .count_r   (cell_count[i]),
      .first_r   (cell_first_r[i]),
      .clear_r   (cell_clear_r[i])
    );
  end

  // Pick the hit count and the last entry's key during the compare cycle.
  always_comb begin
    sel_count_nxt = '0;
    last_key_nxt  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_count_nxt = sel_count_nxt | (cell_first[i] ? cell_count[i] : '0);
      last_key_nxt  = last_key_nxt | (cell_last[i] ? cell_key[i] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == tpc_pkg::ST_CMP) begin
      found_r     <= !clear_chain[CAPACITY];
      sel_count_r <= sel_count_nxt;
      last_key_r  <= last_key_nxt;
    end
  end

  // List length: grows on a miss that does not evict.
  always_comb begin
    len_nxt = len_r;
    if (upd && miss && !evict) begin
      len_nxt = len_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  // Result beat, one cycle wide.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_hit_r         <= found_r;
      out_count_r       <= head_count;
      out_promoted_r    <= promote;
      out_evicted_r     <= evict;
      out_evicted_key_r <= evict ? tpc_pkg::PAGE_KEY_BITS'(last_key_r) : '0;
      out_entry_count_r <= tpc_pkg::ENTRY_COUNT_BITS'(len_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_request_count = out_count_r;
  assign out_promoted      = out_promoted_r;
  assign out_evicted       = out_evicted_r;
  assign out_evicted_key   = out_evicted_key_r;
  assign out_entry_count   = out_entry_count_r;

  // A result beat only follows an update cycle.
  a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == tpc_pkg::ST_UPD))
    else $error("result beat without an update cycle");

  // An accepted request always enters the compare cycle next.
  a_accept_to_compare: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == tpc_pkg::ST_CMP))
    else $error("accepted request did not enter compare");

  // The list never grows past the row of cells.
  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(len_r) <= 32'(CAPACITY))
    else $error("list length beyond capacity");

  // An eviction only happens on a miss with a fresh count and a full list.
  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> (!out_hit && !out_promoted &&
                                    out_request_count == tpc_pkg::COUNT_FIRST &&
                                    $past(len_r) == len_r))
    else $error("eviction outside a full-list miss");

endmodule

`default_nettype wire
